// ===== hdl/mpfp_pkg.sv =====
// Package for the motion packet field parser: payload types, codes and section helpers.
`default_nettype none
package mpfp_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 60;

  localparam logic [7:0] MAGIC_BYTE = 8'hDE;
  localparam logic [3:0] ID_DONE    = 4'd15;
  localparam logic [3:0] ID_NUN_MASK = 4'd6;

  localparam logic RK_VALUE   = 1'b0;
  localparam logic RK_VERDICT = 1'b1;

  localparam int unsigned NUM_SECTIONS = 5;

  // first value id of each optional section, in flag-bit order
  localparam logic [3:0] SECTION_FIRST_ID [NUM_SECTIONS] = '{4'd0, 4'd3, 4'd4, 4'd6, 4'd9};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } mpfp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  value_id;
    logic [31:0] value_word;
    logic        packet_ok;
    logic        run_last;
  } mpfp_out_t;

  // results produced by one byte: an optional value and an optional verdict
  typedef struct packed {
    logic val_push;
    logic ver_push;
  } mpfp_push_t;

  // first selected section at or after section s
  function automatic logic [3:0] first_from(input logic [2:0] s, input logic [4:0] flags);
    logic [3:0] r;
    r = ID_DONE;
    for (int i = NUM_SECTIONS - 1; i >= 0; i--) begin
      if ((3'(i) >= s) && flags[i]) begin
        r = SECTION_FIRST_ID[i];
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] next_id(input logic [3:0] id, input logic [4:0] flags);
    logic [3:0] r;
    case (id)
      4'd2:    r = first_from(3'd1, flags);
      4'd3:    r = first_from(3'd2, flags);
      4'd5:    r = first_from(3'd3, flags);
      4'd8:    r = first_from(3'd4, flags);
      4'd11:   r = ID_DONE;
      default: r = (id < 4'd11) ? id + 4'd1 : ID_DONE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/motion_packet_field_parser.sv =====
// Top level of the motion packet field parser.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (mpfp_in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (mpfp_out_t)
//
// One byte per cycle while in_stall_o is low: the packet state updates in the cycle a byte is taken.
// Results land in a 4-entry queue and leave one per cycle while out_stall_i is low, from the cycle after.
// A byte yielding a value plus a verdict queues both, the value ahead of the verdict.
// in_stall_o rises when fewer than two queue slots are free.
// Reset clears packet state, last sequence and the queue.
`default_nettype none
module motion_packet_field_parser #(
  parameter int unsigned MaxPacketBytes = mpfp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire mpfp_pkg::mpfp_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output mpfp_pkg::mpfp_out_t      out_data_o
);
  import mpfp_pkg::*;

  logic       accept;
  logic       full;
  mpfp_push_t push;
  mpfp_out_t  val_res;
  mpfp_out_t  ver_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  mpfp_parse #(
    .MaxBytes (MaxPacketBytes)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .push_o    (push),
    .val_res_o (val_res),
    .ver_res_o (ver_res)
  );

  mpfp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .val_res_i   (val_res),
    .ver_res_i   (ver_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== hdl/mpfp_parse.sv =====
// Per-byte packet state and field assembly for the motion packet parser.
`default_nettype none
module mpfp_parse #(
  parameter int unsigned MaxBytes = mpfp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire mpfp_pkg::mpfp_in_t in_i,
  output mpfp_pkg::mpfp_push_t   push_o,
  output mpfp_pkg::mpfp_out_t    val_res_o,
  output mpfp_pkg::mpfp_out_t    ver_res_o
);
  import mpfp_pkg::*;

  localparam int unsigned PW = $clog2(MaxBytes + 1);

  logic [7:0]    last_seq_q, last_seq_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [4:0]    flags_q, flags_d;
  logic [31:0]   acc_q, acc_d;
  logic [3:0]    fidx_q, fidx_d;
  logic [1:0]    bif_q, bif_d;
  logic          rej_q, rej_d;

  logic       val_push;
  logic [3:0] val_id;
  logic [31:0] val_word;
  logic [7:0] b;
  logic       eop;
  logic [7:0] seq_base;
  logic       ok;

  assign b   = in_i.data_byte;
  assign eop = in_i.end_of_packet;

  always_comb begin
    last_seq_d = last_seq_q;
    pos_d      = pos_q;
    flags_d    = flags_q;
    acc_d      = acc_q;
    fidx_d     = fidx_q;
    bif_d      = bif_q;
    rej_d      = rej_q;
    val_push   = 1'b0;
    val_id     = fidx_q;
    val_word   = 32'd0;
    seq_base   = (b == 8'd0) ? 8'd0 : last_seq_q;

    if (pos_q < PW'(MaxBytes)) begin
      pos_d = pos_q + PW'(1);
      if (!rej_q) begin
        if (pos_q == PW'(0)) begin
          if (b != MAGIC_BYTE) rej_d = 1'b1;
        end else if (pos_q == PW'(1)) begin
          if (eop) begin
            rej_d = 1'b1;
          end else if (b < seq_base) begin
            rej_d      = 1'b1;
            last_seq_d = seq_base;
          end else begin
            last_seq_d = b;
          end
        end else if (pos_q == PW'(2)) begin
          flags_d = b[4:0];
          fidx_d  = first_from(3'd0, b[4:0]);
        end else if (fidx_q != ID_DONE) begin
          if (fidx_q == ID_NUN_MASK) begin
            val_push = 1'b1;
            val_word = {24'd0, b};
            fidx_d   = next_id(fidx_q, flags_q);
          end else if (bif_q == 2'd3) begin
            val_push = 1'b1;
            val_word = {acc_q[23:0], b};
            acc_d    = 32'd0;
            bif_d    = 2'd0;
            fidx_d   = next_id(fidx_q, flags_q);
          end else begin
            acc_d = {acc_q[23:0], b};
            bif_d = bif_q + 2'd1;
          end
        end
      end
    end

    ok = !rej_d && (pos_d >= PW'(3)) && (fidx_d == ID_DONE);

    if (eop) begin
      pos_d   = '0;
      flags_d = '0;
      acc_d   = '0;
      fidx_d  = '0;
      bif_d   = '0;
      rej_d   = 1'b0;
    end
  end

  always_comb begin
    push_o.val_push = accept_i & val_push;
    push_o.ver_push = accept_i & eop;

    val_res_o.result_kind = RK_VALUE;
    val_res_o.value_id    = val_id;
    val_res_o.value_word  = val_word;
    val_res_o.packet_ok   = 1'b0;
    val_res_o.run_last    = !eop;

    ver_res_o.result_kind = RK_VERDICT;
    ver_res_o.value_id    = 4'd0;
    ver_res_o.value_word  = 32'd0;
    ver_res_o.packet_ok   = ok;
    ver_res_o.run_last    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      pos_q      <= '0;
      flags_q    <= '0;
      acc_q      <= '0;
      fidx_q     <= '0;
      bif_q      <= '0;
      rej_q      <= 1'b0;
    end else if (accept_i) begin
      last_seq_q <= last_seq_d;
      pos_q      <= pos_d;
      flags_q    <= flags_d;
      acc_q      <= acc_d;
      fidx_q     <= fidx_d;
      bif_q      <= bif_d;
      rej_q      <= rej_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mpfp_out_fifo.sv =====
// Four-entry result queue with two write slots per cycle and one read.
`default_nettype none
module mpfp_out_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mpfp_pkg::mpfp_push_t push_i,
  input  wire mpfp_pkg::mpfp_out_t  val_res_i,
  input  wire mpfp_pkg::mpfp_out_t  ver_res_i,
  output logic                      full_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output mpfp_pkg::mpfp_out_t       out_data_o
);
  import mpfp_pkg::*;

  mpfp_out_t  mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;
  logic       push0, push1;
  logic [2:0] n_push;
  mpfp_out_t  e0;

  assign push0  = push_i.val_push | push_i.ver_push;
  assign push1  = push_i.val_push & push_i.ver_push;
  assign e0     = push_i.val_push ? val_res_i : ver_res_i;
  assign n_push = 3'(push_i.val_push) + 3'(push_i.ver_push);

  // room for a two-result transaction must be there before accepting a byte
  assign full_o      = count_q > 3'd2;
  assign out_valid_o = count_q != 3'd0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push[1:0];
    rd_ptr_d = rd_ptr_q + 2'(pop);
    count_d  = count_q + n_push - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) mem_q[wr_ptr_q] <= e0;
    if (push1) mem_q[wr_ptr_q + 2'd1] <= ver_res_i;
  end

endmodule
`default_nettype wire

// ===== tb/motion_packet_field_parser_checker.sv =====
// Checker for the motion packet field parser: tracks the datagram parse and compares every result.
`timescale 1ns / 100ps
module motion_packet_field_parser_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mpfp_pkg::mpfp_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mpfp_pkg::mpfp_out_t out_data_i,
  output int                  mismatches_o,
  output int                  outstanding_o,
  output int                  updates_o,
  output int                  verdicts_o,
  output int                  accepted_o
);
  import mpfp_pkg::*;

  localparam int MaxBytes = MAX_PACKET_BYTES_DEF;

  localparam logic [3:0] ID_ACCEL_X   = 4'd0;
  localparam logic [3:0] ID_ACCEL_Z   = 4'd2;
  localparam logic [3:0] ID_BUTTONS   = 4'd3;
  localparam logic [3:0] ID_POINTER_X = 4'd4;
  localparam logic [3:0] ID_POINTER_Y = 4'd5;
  localparam logic [3:0] ID_NUN_Y     = 4'd8;
  localparam logic [3:0] ID_NUN_ACC_X = 4'd9;
  localparam logic [3:0] ID_NUN_ACC_Z = 4'd11;

  localparam int SEC_ACCEL     = 0;
  localparam int SEC_BUTTONS   = 1;
  localparam int SEC_POINTER   = 2;
  localparam int SEC_NUNCHUK   = 3;
  localparam int SEC_NUN_ACCEL = 4;

  // packet parse state
  logic [7:0]  last_seq;
  int          byte_pos;
  logic [4:0]  sect_flags;
  logic [31:0] word_acc;
  logic [3:0]  field_id;
  logic [1:0]  byte_idx;
  logic        rejected;

  mpfp_out_t field_reports_q[$];
  mpfp_out_t want;

  int n_mismatch = 0;
  int n_outstanding = 0;
  int n_updates = 0;
  int n_verdicts = 0;
  int n_accepted = 0;

  assign mismatches_o  = n_mismatch;
  assign outstanding_o = n_outstanding;
  assign updates_o     = n_updates;
  assign verdicts_o    = n_verdicts;
  assign accepted_o    = n_accepted;

  // first value id of the first selected section at or after from_sec
  function automatic logic [3:0] section_start(input int from_sec, input logic [4:0] fl);
    logic [3:0] id;
    id = ID_DONE;
    for (int s = SEC_NUN_ACCEL; s >= from_sec; s--) begin
      if (fl[s]) begin
        case (s)
          SEC_ACCEL:   id = ID_ACCEL_X;
          SEC_BUTTONS: id = ID_BUTTONS;
          SEC_POINTER: id = ID_POINTER_X;
          SEC_NUNCHUK: id = ID_NUN_MASK;
          default:     id = ID_NUN_ACC_X;
        endcase
      end
    end
    return id;
  endfunction

  function automatic logic [3:0] advance_field(input logic [3:0] id, input logic [4:0] fl);
    case (id)
      ID_ACCEL_Z:   return section_start(SEC_BUTTONS, fl);
      ID_BUTTONS:   return section_start(SEC_POINTER, fl);
      ID_POINTER_Y: return section_start(SEC_NUNCHUK, fl);
      ID_NUN_Y:     return section_start(SEC_NUN_ACCEL, fl);
      default:      return (id < ID_NUN_ACC_Z) ? id + 4'd1 : ID_DONE;
    endcase
  endfunction

  task automatic clear_packet();
    byte_pos   = 0;
    sect_flags = '0;
    word_acc   = '0;
    field_id   = '0;
    byte_idx   = '0;
    rejected   = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    mpfp_out_t made [2];
    int        n;
    int        pos;
    logic      ok;
    n = 0;
    made[0] = '0;
    made[1] = '0;
    if (byte_pos < MaxBytes) begin
      pos = byte_pos;
      byte_pos++;
      if (!rejected) begin
        if (pos == 0) begin
          if (b != MAGIC_BYTE) rejected = 1'b1;
        end else if (pos == 1) begin
          // end mark on the sequence byte leaves the sequence untouched
          if (eop) begin
            rejected = 1'b1;
          end else begin
            if (b == 8'h00) last_seq = 8'h00;
            if (b < last_seq) rejected = 1'b1;
            else last_seq = b;
          end
        end else if (pos == 2) begin
          sect_flags = b[4:0];
          field_id   = section_start(SEC_ACCEL, b[4:0]);
        end else if (field_id != ID_DONE) begin
          if (field_id == ID_NUN_MASK) begin
            made[n] = '{result_kind: RK_VALUE, value_id: field_id, value_word: {24'h0, b},
                        packet_ok: 1'b0, run_last: 1'b0};
            n++;
            field_id = advance_field(field_id, sect_flags);
          end else begin
            word_acc = {word_acc[23:0], b};
            if (byte_idx == 2'd3) begin
              made[n] = '{result_kind: RK_VALUE, value_id: field_id, value_word: word_acc,
                          packet_ok: 1'b0, run_last: 1'b0};
              n++;
              word_acc = '0;
              byte_idx = '0;
              field_id = advance_field(field_id, sect_flags);
            end else begin
              byte_idx = byte_idx + 2'd1;
            end
          end
        end
      end
    end
    if (eop) begin
      ok = !rejected && byte_pos >= 3 && field_id == ID_DONE;
      made[n] = '{result_kind: RK_VERDICT, value_id: 4'd0, value_word: 32'd0,
                  packet_ok: ok, run_last: 1'b0};
      n++;
      clear_packet();
    end
    if (n > 0) made[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) field_reports_q = {field_reports_q, made[i]};
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
    n_mismatch++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq = 8'h00;
      clear_packet();
      field_reports_q.delete();
      n_outstanding = 0;
    end else begin
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i.data_byte, in_data_i.end_of_packet);
      if (out_valid_i && !out_stall_i) begin
        if (field_reports_q.size() == 0) begin
          n_mismatch++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual kind %0b id %0d word 0x%08h ok %0b last %0b"},
                   $time, out_data_i.result_kind, out_data_i.value_id,
                   out_data_i.value_word, out_data_i.packet_ok, out_data_i.run_last);
        end else begin
          want = field_reports_q.pop_front();
          if (out_data_i.result_kind !== want.result_kind)
            report_field("result_kind", want.result_kind, out_data_i.result_kind);
          if (out_data_i.value_id !== want.value_id)
            report_field("value_id", want.value_id, out_data_i.value_id);
          if (out_data_i.value_word !== want.value_word)
            report_field("value_word", want.value_word, out_data_i.value_word);
          if (out_data_i.packet_ok !== want.packet_ok)
            report_field("packet_ok", want.packet_ok, out_data_i.packet_ok);
          if (out_data_i.run_last !== want.run_last)
            report_field("run_last", want.run_last, out_data_i.run_last);
          if (want.result_kind == RK_VERDICT) begin
            n_verdicts++;
            if (want.packet_ok) n_accepted++;
          end else begin
            n_updates++;
          end
        end
      end
      n_outstanding = field_reports_q.size();
    end
  end

endmodule

// ===== tb/motion_packet_field_parser_test.sv =====
// Testbench top for the motion packet field parser: clock, reset, datagram stimulus and verdict.
`timescale 1ns / 100ps
module motion_packet_field_parser_test;
  import mpfp_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int ItemTarget = 1550;
  localparam int HoldCycles = 300;

  localparam int SEC_ACCEL     = 0;
  localparam int SEC_BUTTONS   = 1;
  localparam int SEC_POINTER   = 2;
  localparam int SEC_NUNCHUK   = 3;
  localparam int SEC_NUN_ACCEL = 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  mpfp_in_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mpfp_out_t out_data;

  int mismatches, outstanding, updates, verdicts, accepted;

  int unsigned cycles = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int input_stalls = 0;
  int seq_mirror = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic [7:0] pkt_bytes[$];

  motion_packet_field_parser u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  motion_packet_field_parser_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .updates_o    (updates),
    .verdicts_o   (verdicts),
    .accepted_o   (accepted)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("motion_packet_field_parser_test: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches, and one long hold-off on request
  initial begin : receiver
    int stall_left, calm_left, hold_left, r;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done && hold_left == 0) hold_left = HoldCycles;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0) hold_done <= 1'b1;
      end else begin
        if (stall_left == 0 && calm_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 8)       calm_left  = $urandom_range(40, 150);
          else if (r < 11) stall_left = $urandom_range(15, 40);
          else if (r < 45) stall_left = $urandom_range(1, 3);
          else             calm_left  = $urandom_range(1, 5);
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
          calm_left--;
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 8'h00;
    if (r < 16) return 8'hFF;
    if (r < 20) return 8'h80;
    if (r < 24) return 8'h7F;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] next_seq();
    int r, s;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      s = 0;
    end else if (r < 25) begin
      s = seq_mirror;
    end else if (r < 30) begin
      s = 255;
    end else begin
      s = seq_mirror + $urandom_range(1, 6);
      if (s > 255) s = 0;
    end
    return 8'(s);
  endfunction

  task automatic add_bytes(input int count);
    repeat (count) pkt_bytes = {pkt_bytes, rand_byte()};
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap, r;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5)       burst_left = $urandom_range(20, 80);
        else if (r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else             gap = $urandom_range(20, 50);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{data_byte: b, end_of_packet: eop};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_packet();
    int final_idx;
    final_idx = pkt_bytes.size() - 1;
    // track the sequence the parser will hold, to aim stale packets
    if (pkt_bytes.size() >= 3 && pkt_bytes[0] == MAGIC_BYTE) begin
      if (pkt_bytes[1] == 8'h00) seq_mirror = 0;
      if (int'(pkt_bytes[1]) >= seq_mirror) seq_mirror = pkt_bytes[1];
    end
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == final_idx);
    packets_sent++;
  endtask

  // sender pause: hold valid low until the checker has seen every result
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic build_valid_packet();
    logic [4:0] sel;
    int r, body;
    sel = ($urandom_range(0, 99) < 15) ? 5'h1F : 5'($urandom_range(0, 31));
    pkt_bytes.delete();
    pkt_bytes = {pkt_bytes, MAGIC_BYTE};
    pkt_bytes = {pkt_bytes, next_seq()};
    pkt_bytes = {pkt_bytes, {3'($urandom_range(0, 7)), sel}};
    if (sel[SEC_ACCEL])     add_bytes(12);
    if (sel[SEC_BUTTONS])   add_bytes(4);
    if (sel[SEC_POINTER])   add_bytes(8);
    if (sel[SEC_NUNCHUK])   add_bytes(9);
    if (sel[SEC_NUN_ACCEL]) add_bytes(12);
    body = pkt_bytes.size() - 3;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      add_bytes($urandom_range(1, 8));
    end else if (r < 27 && body > 0) begin
      repeat ($urandom_range(1, body)) void'(pkt_bytes.pop_back());
    end else if (r < 33) begin
      // runs past the receive limit
      add_bytes($urandom_range(61, 70) - pkt_bytes.size());
    end
  endtask

  task automatic build_random_packet();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      build_valid_packet();
    end else if (r < 78) begin
      build_valid_packet();
      b = rand_byte();
      pkt_bytes[0] = (b == MAGIC_BYTE) ? 8'h00 : b;
    end else if (r < 85) begin
      build_valid_packet();
      if (seq_mirror >= 2) pkt_bytes[1] = 8'($urandom_range(1, seq_mirror - 1));
    end else if (r < 92) begin
      pkt_bytes.delete();
      pkt_bytes = {pkt_bytes, (($urandom_range(0, 3) != 0) ? MAGIC_BYTE : rand_byte())};
      if ($urandom_range(0, 1) != 0) pkt_bytes = {pkt_bytes, rand_byte()};
    end else begin
      pkt_bytes.delete();
      add_bytes($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte packet
    pkt_bytes = '{MAGIC_BYTE};
    send_packet();
    // end mark on the sequence byte
    pkt_bytes = '{MAGIC_BYTE, 8'h05};
    send_packet();
    // sequence restart, no sections selected
    pkt_bytes = '{MAGIC_BYTE, 8'h00, 8'h00};
    send_packet();
    // wrong magic
    pkt_bytes = '{8'h12, 8'h01, 8'h00};
    send_packet();
    // nunchuk mask goes out, then the first word is cut short
    pkt_bytes = '{MAGIC_BYTE, 8'h04, 8'h08, 8'hFF, 8'h80, 8'h00, 8'h00};
    send_packet();
    // stale sequence
    pkt_bytes = '{MAGIC_BYTE, 8'h02, 8'h00};
    send_packet();
    // unused flag bits set, trailing byte ignored
    pkt_bytes = '{MAGIC_BYTE, 8'h04, 8'hE0, 8'hAA};
    send_packet();
    // buttons word all ones
    pkt_bytes = '{MAGIC_BYTE, 8'h06, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet();
    wait_quiet();

    while (bytes_sent < ItemTarget) begin
      if (!pressure_done && bytes_sent >= ItemTarget / 3) begin
        // receiver holds off while the sender keeps pushing back to back
        pressure_done = 1'b1;
        hold_req <= 1'b1;
        no_gaps = 1'b1;
        while (!hold_done) begin
          build_valid_packet();
          send_packet();
        end
        no_gaps = 1'b0;
        hold_req <= 1'b0;
        wait_quiet();
      end
      build_random_packet();
      send_packet();
      if ($urandom_range(0, 19) == 0) wait_quiet();
    end

    wait_quiet();
    repeat (16) @(posedge clk);
    @(negedge clk);
    $display("Run: %0d bytes in %0d datagrams, input held back on %0d cycles.",
             bytes_sent, packets_sent, input_stalls);
    $display("Checked %0d field updates and %0d verdicts (%0d packets accepted).",
             updates, verdicts, accepted);
    if (mismatches == 0 && outstanding == 0) begin
      $display("motion_packet_field_parser_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
      $display("motion_packet_field_parser_test: FAIL");
    end
    $finish;
  end

endmodule
